// ===== hdl/qte_pkg.sv =====
// Shared widths, pipeline payload types and the arctangent table for the Euler converter.
package qte_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  localparam int W_IN   = 16;
  localparam int W_PROD = 32;
  localparam int W_SUM  = 34;
  localparam int W_S    = 30;
  localparam int SQ_W   = 57;
  localparam int ROOT_W = 29;
  localparam int W_LANE = 36;
  localparam int W_ACC  = 33;

  localparam longint Q28_ONE = 64'sd268435456;
  localparam longint ONE_RAD = 64'sd375493621;
  localparam longint DEG90_U = 64'sd589824000;

  typedef struct packed {
    logic signed [W_SUM-1:0] yn;
    logic signed [W_SUM-1:0] yd;
    logic signed [W_SUM-1:0] rn;
    logic signed [W_SUM-1:0] rd;
    logic signed [W_S-1:0]   s;
  } qte_terms_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
    qte_terms_t        terms;
  } qte_sqrt_t;

  typedef struct packed {
    logic signed [W_LANE-1:0] x;
    logic signed [W_LANE-1:0] y;
    logic signed [W_ACC-1:0]  acc;
    logic                     zero;
  } qte_lane_t;

  typedef struct packed {
    qte_lane_t yaw;
    qte_lane_t pitch;
    qte_lane_t roll;
  } qte_vec_t;

  // Angle of step i in units of 2^-16 centidegree.
  function automatic logic signed [W_ACC-1:0] atan_at(input int i);
    logic signed [W_ACC-1:0] a;
    case (i)
      0:  a = 33'sd294912000;
      1:  a = 33'sd174096719;
      2:  a = 33'sd91987925;
      3:  a = 33'sd46694507;
      4:  a = 33'sd23437865;
      5:  a = 33'sd11730358;
      6:  a = 33'sd5866610;
      7:  a = 33'sd2933484;
      8:  a = 33'sd1466764;
      9:  a = 33'sd733385;
      10: a = 33'sd366693;
      11: a = 33'sd183346;
      default: a = W_ACC'(ONE_RAD >>> i);
    endcase
    return a;
  endfunction

  // Turns a left half-plane vector into the right half-plane before the micro-rotations.
  function automatic qte_lane_t prerotate(input logic signed [W_LANE-1:0] x,
                                          input logic signed [W_LANE-1:0] y);
    qte_lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x    = x;
    l.y    = y;
    l.acc  = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.x   = y;
        l.y   = -x;
        l.acc = W_ACC'(DEG90_U);
      end else begin
        l.x   = -y;
        l.y   = x;
        l.acc = -W_ACC'(DEG90_U);
      end
    end
    return l;
  endfunction

endpackage

// ===== hdl/qte_ifs.sv =====
// Stream interfaces for quaternion beats in and Euler angle beats out.
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_centideg;
  logic signed [14:0] pitch_centideg;
  logic signed [15:0] roll_centideg;
  modport source(output valid, yaw_centideg, pitch_centideg, roll_centideg, input ready);
  modport sink(input valid, yaw_centideg, pitch_centideg, roll_centideg, output ready);
endinterface

// ===== hdl/qte_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root; decides a single root bit.
module qte_sqrt_cell
  import qte_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_vld,
  input  qte_sqrt_t in_d,
  output logic      out_vld,
  output qte_sqrt_t out_d
);

  logic      vld_r;
  qte_sqrt_t d_r, d_nxt;
  logic [SQ_W:0] trial;

  // Trial is (root + 2^BIT)^2 - root^2; root holds only bits above BIT here.
  always_comb begin
    trial = ((SQ_W+1)'(in_d.root) << (BIT + 1)) | ((SQ_W+1)'(1) << (2 * BIT));
    d_nxt = in_d;
    if ({1'b0, in_d.rem} >= trial) begin
      d_nxt.rem  = in_d.rem - trial[SQ_W-1:0];
      d_nxt.root = in_d.root | (ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

// ===== hdl/qte_cordic_cell.sv =====
// One CORDIC vectoring cell, doing a micro-rotation on each of the three lanes.
module qte_cordic_cell
  import qte_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_vld,
  input  qte_vec_t in_d,
  output logic     out_vld,
  output qte_vec_t out_d
);

  localparam logic signed [W_ACC-1:0] ANG = atan_at(STEP);

  logic     vld_r;
  qte_vec_t d_r, d_nxt;

  function automatic qte_lane_t rotate(input qte_lane_t l);
    qte_lane_t o;
    logic signed [W_LANE-1:0] xs, ys;
    xs = l.x >>> STEP;
    ys = l.y >>> STEP;
    o  = l;
    if (l.y >= 0) begin
      o.x   = l.x + ys;
      o.y   = l.y - xs;
      o.acc = l.acc + ANG;
    end else begin
      o.x   = l.x - ys;
      o.y   = l.y + xs;
      o.acc = l.acc - ANG;
    end
    return o;
  endfunction

  always_comb begin
    d_nxt.yaw   = rotate(in_d.yaw);
    d_nxt.pitch = rotate(in_d.pitch);
    d_nxt.roll  = rotate(in_d.roll);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

// ===== hdl/quaternion_to_euler_zyx.sv =====
// Top level: quaternion to ZYX Euler angles through a square-root chain and a CORDIC chain.
//
//   Channel  Direction  Beat contents
//   in_ch    sink       quat_w, quat_x, quat_y, quat_z (signed Q2.14)
//   out_ch   source     yaw_centideg, pitch_centideg, roll_centideg
//
// One beat is accepted every cycle while out_ch is not stalled; the path runs through
// three arithmetic stages, 29 square-root cells, one pre-rotation stage, the
// CORDIC cells and the output register. Reset clears every stage's valid bit.
// A stall on out_ch freezes the whole pipeline, and in_ch.ready drops with it.
module quaternion_to_euler_zyx
  import qte_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input logic clk,
  input logic rst_n,
  qte_in_if.sink    in_ch,
  qte_out_if.source out_ch
);

  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Products.
  logic v1_r;
  logic signed [W_PROD-1:0] wz_r, xy_r, yy_r, zz_r, wy_r, zx_r, wx_r, xx_r, yz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wz_r <= in_ch.quat_w * in_ch.quat_z;
      xy_r <= in_ch.quat_x * in_ch.quat_y;
      yy_r <= in_ch.quat_y * in_ch.quat_y;
      zz_r <= in_ch.quat_z * in_ch.quat_z;
      wy_r <= in_ch.quat_w * in_ch.quat_y;
      zx_r <= in_ch.quat_z * in_ch.quat_x;
      wx_r <= in_ch.quat_w * in_ch.quat_x;
      xx_r <= in_ch.quat_x * in_ch.quat_x;
      yz_r <= in_ch.quat_y * in_ch.quat_z;
    end
  end

  // Numerators, denominators and the clamped pitch argument.
  logic v2_r;
  qte_terms_t terms_r, terms_nxt;
  logic signed [W_SUM-2:0] yn_h, rn_h, sd_h, yd_h, rd_h;
  logic signed [W_SUM-1:0] s_full;

  always_comb begin
    yn_h   = (W_SUM-1)'(wz_r) + (W_SUM-1)'(xy_r);
    rn_h   = (W_SUM-1)'(wx_r) + (W_SUM-1)'(yz_r);
    yd_h   = (W_SUM-1)'(yy_r) + (W_SUM-1)'(zz_r);
    rd_h   = (W_SUM-1)'(xx_r) + (W_SUM-1)'(yy_r);
    sd_h   = (W_SUM-1)'(wy_r) - (W_SUM-1)'(zx_r);
    s_full = {sd_h, 1'b0};
    terms_nxt.yn = {yn_h, 1'b0};
    terms_nxt.rn = {rn_h, 1'b0};
    terms_nxt.yd = W_SUM'(Q28_ONE) - {yd_h, 1'b0};
    terms_nxt.rd = W_SUM'(Q28_ONE) - {rd_h, 1'b0};
    if (s_full > W_SUM'(Q28_ONE)) begin
      terms_nxt.s = W_S'(Q28_ONE);
    end else if (s_full < -W_SUM'(Q28_ONE)) begin
      terms_nxt.s = -W_S'(Q28_ONE);
    end else begin
      terms_nxt.s = s_full[W_S-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terms_r <= terms_nxt;
    end
  end

  // Radicand 1 - s*s in Q.56.
  logic v3_r;
  qte_sqrt_t sq_r, sq_nxt;
  logic [ROOT_W-1:0]   sm;
  logic [2*ROOT_W-1:0] sm_sq;

  always_comb begin
    sm           = terms_r.s < 0 ? ROOT_W'(-terms_r.s) : ROOT_W'(terms_r.s);
    sm_sq        = sm * sm;
    sq_nxt.rem   = (SQ_W'(1) << (SQ_W - 1)) - sm_sq[SQ_W-1:0];
    sq_nxt.root  = '0;
    sq_nxt.terms = terms_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  // Square-root chain, most significant root bit first.
  logic      sq_vld [0:ROOT_W];
  qte_sqrt_t sq_d   [0:ROOT_W];
  assign sq_vld[0] = v3_r;
  assign sq_d[0]   = sq_r;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    qte_sqrt_cell #(.BIT(ROOT_W - 1 - k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_vld (sq_vld[k]),
      .in_d   (sq_d[k]),
      .out_vld(sq_vld[k+1]),
      .out_d  (sq_d[k+1])
    );
  end

  // Pre-rotation of the three vectors.
  logic     vp_r;
  qte_vec_t pre_r;
  qte_terms_t tf;
  assign tf = sq_d[ROOT_W].terms;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (en) begin
      vp_r <= sq_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r.yaw   <= prerotate(W_LANE'(tf.yd), W_LANE'(tf.yn));
      pre_r.pitch <= prerotate(W_LANE'(sq_d[ROOT_W].root), W_LANE'(tf.s));
      pre_r.roll  <= prerotate(W_LANE'(tf.rd), W_LANE'(tf.rn));
    end
  end

  // CORDIC chain.
  logic     cv [0:CORDIC_STEPS];
  qte_vec_t cd [0:CORDIC_STEPS];
  assign cv[0] = vp_r;
  assign cd[0] = pre_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    qte_cordic_cell #(.STEP(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .in_vld (cv[i]),
      .in_d   (cd[i]),
      .out_vld(cv[i+1]),
      .out_d  (cd[i+1])
    );
  end

  // Rounding half up, then saturation; a zero vector gives zero.
  function automatic logic signed [W_ACC-16:0] to_centi(input qte_lane_t l,
                                                        input int lim);
    logic signed [W_ACC:0]    t;
    logic signed [W_ACC-16:0] r;
    t = (W_ACC+1)'(l.acc) + (W_ACC+1)'(32768);
    r = (W_ACC-15)'(t >>> 16);
    if (l.zero) begin
      r = '0;
    end else if (r > (W_ACC-15)'(lim)) begin
      r = (W_ACC-15)'(lim);
    end else if (r < -(W_ACC-15)'(lim)) begin
      r = -(W_ACC-15)'(lim);
    end
    return r;
  endfunction

  logic                 vo_r;
  logic signed [15:0]   yaw_r, roll_r;
  logic signed [14:0]   pitch_r;
  logic signed [W_ACC-16:0] yaw_c, pitch_c, roll_c;

  assign yaw_c   = to_centi(cd[CORDIC_STEPS].yaw, 18000);
  assign pitch_c = to_centi(cd[CORDIC_STEPS].pitch, 9000);
  assign roll_c  = to_centi(cd[CORDIC_STEPS].roll, 18000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_r   <= yaw_c[15:0];
      pitch_r <= pitch_c[14:0];
      roll_r  <= roll_c[15:0];
    end
  end

  assign out_ch.valid          = vo_r;
  assign out_ch.yaw_centideg   = yaw_r;
  assign out_ch.pitch_centideg = pitch_r;
  assign out_ch.roll_centideg  = roll_r;

  a_yaw_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.yaw_centideg <= 16'sd18000 && out_ch.yaw_centideg >= -16'sd18000))
    else $error("yaw beyond its range");

  a_pitch_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.pitch_centideg <= 15'sd9000 &&
                      out_ch.pitch_centideg >= -15'sd9000))
    else $error("pitch beyond its range");

  a_reset_idle : assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result beat valid straight after reset");

endmodule

// ===== verif/quaternion_to_euler_zyx_tb.sv =====
// Self-checking testbench for the quaternion to ZYX Euler angle converter.
`timescale 1ns / 1ps

module quaternion_to_euler_zyx_tb;
  import qte_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int N_RANDOM = 1828;
  localparam int LATENCY = STEPS + 34;
  localparam int PAUSE_AT = 40;
  localparam int CALM_TAIL = 200;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct {
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } euler_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qte_in_if  in_ch();
  qte_out_if out_ch();

  quaternion_to_euler_zyx dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  quat_t  quat_queue[$];
  euler_t euler_queue[$];
  int     n_total = 0;
  int     n_sent = 0;
  bit     failed = 1'b0;
  bit     calm = 1'b0;
  bit     in_taken = 1'b0;
  int     in_gap = 0;
  int     out_stall = 0;

  // Arctangent of y/x in units of 2^-16 centidegree.
  function automatic longint vector_angle(longint y, longint x);
    longint acc, t, xs, ys, a;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = DEG90_U;
      end else begin
        x = -y; y = t; acc = -DEG90_U;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      a = (i < 12) ? longint'(atan_at(i)) : (ONE_RAD >>> i);
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; acc += a;
      end else begin
        x = x - ys; y = y + xs; acc -= a;
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint centideg(longint acc, longint lim);
    longint r;
    r = (acc + 32768) >>> 16;
    if (r < -lim) r = -lim;
    if (r > lim) r = lim;
    return r;
  endfunction

  function automatic euler_t euler_of(quat_t q);
    longint w, x, y, z, s, sm;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    e.yaw = 16'(centideg(vector_angle(2 * (w * z + x * y),
                                      Q28_ONE - 2 * (y * y + z * z)), 18000));
    // The pitch argument is clamped to plus or minus one before the arcsine.
    s = 2 * (w * y - z * x);
    if (s > Q28_ONE) s = Q28_ONE;
    if (s < -Q28_ONE) s = -Q28_ONE;
    sm = (s < 0) ? -s : s;
    e.pitch = 15'(centideg(vector_angle(s,
              longint'(int_sqrt((64'd1 << 56) - longint'(sm) * longint'(sm)))), 9000));
    e.roll = 16'(centideg(vector_angle(2 * (w * x + y * z),
                                       Q28_ONE - 2 * (x * x + y * y)), 18000));
    return e;
  endfunction

  function automatic void add_quat(int w, int x, int y, int z);
    quat_t q;
    q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
    quat_queue.push_back(q);
    n_total++;
  endfunction

  function automatic int jitter(int centre, int spread);
    int v;
    v = centre + $signed($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  initial begin
    int kind;
    int c1, c2, c3, c4;
    // Directed beats: identity, zero, extremes, axis turns and degenerate vectors.
    add_quat(16384, 0, 0, 0);
    add_quat(0, 0, 0, 0);
    add_quat(32767, 32767, 32767, 32767);
    add_quat(-32768, -32768, -32768, -32768);
    add_quat(32767, -32768, 32767, -32768);
    add_quat(-32768, 32767, -32768, 32767);
    add_quat(0, 16384, 0, 0);
    add_quat(0, 0, 16384, 0);
    add_quat(0, 0, 0, 16384);
    add_quat(0, 0, 8192, 8192);
    add_quat(0, 8192, 8192, 0);
    add_quat(11585, 0, 11585, 0);
    add_quat(11585, 0, -11585, 0);
    add_quat(16384, 0, 16384, 0);
    add_quat(16384, 0, -16384, 0);
    add_quat(0, 16384, 0, -16384);
    add_quat(11585, 11585, 0, 0);
    add_quat(11585, 0, 0, -11585);
    add_quat(-16384, 0, 0, 0);
    add_quat(1, -1, 1, -1);
    add_quat(8192, 8192, 8192, 8192);
    add_quat(8192, -8192, 8192, 8192);
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(9);
      if (kind < 3) begin
        add_quat($signed(16'($urandom)), $signed(16'($urandom)),
                 $signed(16'($urandom)), $signed(16'($urandom)));
      end else if (kind < 8) begin
        // Quaternions whose components each lie within about plus or minus one half.
        c1 = $signed($urandom_range(32768)) - 16384;
        c2 = $signed($urandom_range(32768)) - 16384;
        c3 = $signed($urandom_range(32768)) - 16384;
        c4 = $signed($urandom_range(32768)) - 16384;
        add_quat(jitter(c1 / 2, 64), jitter(c2 / 2, 64), jitter(c3 / 2, 64),
                 jitter(c4 / 2, 64));
      end else begin
        // Close to gimbal lock, where the pitch argument reaches and passes one.
        c1 = ($urandom_range(1)) ? 11585 : -11585;
        add_quat(jitter(c1, 200), jitter(0, 200), jitter(c1, 200), jitter(0, 200));
      end
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (n_sent == n_total && euler_queue.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (!failed && euler_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.quat_w = '0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    out_ch.ready = 1'b0;
  end

  // Accepted input beats become expectations at the same edge they are taken.
  always @(posedge clk) begin
    quat_t q;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      q.w = in_ch.quat_w; q.x = in_ch.quat_x; q.y = in_ch.quat_y; q.z = in_ch.quat_z;
      euler_queue.push_back(euler_of(q));
      n_sent <= n_sent + 1;
    end
  end

  // Driver: a beat is held until taken; a random gap or the PAUSE_AT drain may follow.
  always @(negedge clk) begin
    quat_t q;
    calm <= (n_total - n_sent) < CALM_TAIL;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (n_sent == PAUSE_AT && euler_queue.size() != 0) begin
        in_ch.valid <= 1'b0;
      end else if (quat_queue.size() > 0) begin
        q = quat_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.quat_w <= q.w;
        in_ch.quat_x <= q.x;
        in_ch.quat_y <= q.y;
        in_ch.quat_z <= q.z;
        if (!calm && $urandom_range(7) == 0) in_gap <= $urandom_range(1, 6);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(7) == 0) out_stall <= $urandom_range(1, 6);
    end
  end

  always @(posedge clk) begin
    euler_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (euler_queue.size() == 0) begin
        $display("%0t: unexpected beat yaw=%0d pitch=%0d roll=%0d", $time,
                 out_ch.yaw_centideg, out_ch.pitch_centideg, out_ch.roll_centideg);
        failed = 1'b1;
      end else begin
        e = euler_queue.pop_front();
        if (out_ch.yaw_centideg !== e.yaw) begin
          $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, out_ch.yaw_centideg);
          failed = 1'b1;
        end
        if (out_ch.pitch_centideg !== e.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
                   out_ch.pitch_centideg);
          failed = 1'b1;
        end
        if (out_ch.roll_centideg !== e.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, e.roll, out_ch.roll_centideg);
          failed = 1'b1;
        end
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
